// ----- hw/rtl/md5_pkg.sv -----
// Shared constants and round functions of the MD5 stream hash.
package md5_pkg;

    localparam int WordW      = 32;
    localparam int BlockWords = 16;
    localparam int WordAddrW  = $clog2(BlockWords);

    localparam logic [WordW-1:0] Init0 = 32'h67452301;
    localparam logic [WordW-1:0] Init1 = 32'hefcdab89;
    localparam logic [WordW-1:0] Init2 = 32'h98badcfe;
    localparam logic [WordW-1:0] Init3 = 32'h10325476;

    localparam logic [7:0] PadMark   = 8'h80;
    localparam logic [5:0] LenPos    = 6'd56;
    localparam logic [5:0] LastPos   = 6'd63;
    localparam logic [5:0] LastRound = 6'd63;

    function automatic logic [WordW-1:0] md5_init(input logic [1:0] idx);
        logic [WordW-1:0] v;
        case (idx)
            2'd0:    v = Init0;
            2'd1:    v = Init1;
            2'd2:    v = Init2;
            default: v = Init3;
        endcase
        return v;
    endfunction

    function automatic logic [WordW-1:0] md5_round_const(input logic [5:0] rnd);
        logic [WordW-1:0] k;
        case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [WordAddrW-1:0] md5_msg_index(input logic [5:0] rnd);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            default: g = 4'(i4 * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [WordW-1:0] md5_mix(input logic [1:0] phase,
                                                 input logic [WordW-1:0] b,
                                                 input logic [WordW-1:0] c,
                                                 input logic [WordW-1:0] d);
        logic [WordW-1:0] f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [WordW-1:0] md5_rotl(input logic [WordW-1:0] v,
                                                  input logic [4:0] s);
        logic [2*WordW-1:0] dbl;
        dbl = {v, v} << s;
        return dbl[2*WordW-1:WordW];
    endfunction

endpackage

// ----- hw/rtl/md5_if.sv -----
// Stream channels of the MD5 hash: message bytes in, digest words out.
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ----- hw/rtl/md5_ram.sv -----
// Generic simple dual-port RAM with registered read.
module md5_ram #(
    parameter int Width = md5_pkg::WordW,
    parameter int Depth = md5_pkg::BlockWords
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/md5_stream_hash.sv -----
// MD5 stream hash top level: byte gathering, padding, round unit and digest output.
//
// The block takes one message transaction per cycle while it gathers a 64-byte
// block; the byte that completes a block starts a compression (a load state,
// 64 rounds through a single round unit that reads one message word per cycle
// from the block memory, a finalize state), during which no input is taken.
// On end of message the padding bytes are written one per cycle, followed by one
// or two compressions, and the digest then leaves as four 32-bit transactions,
// word 0 first, each word's low byte the earlier digest byte. No input is taken
// from the end-of-message transaction until the last digest word has been
// taken; the block then holds the initial chaining value again for the next
// message.
module md5_stream_hash (
    input  logic             clk,
    input  logic             rst_n,
    md5_in_if.sink           msg,
    md5_out_if.source        digest
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_COMP = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } md5_state_t;

    localparam int W  = md5_pkg::WordW;
    localparam int AW = md5_pkg::WordAddrW;

    md5_state_t state_reg, state_next;

    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [23:0] asm_reg, asm_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [1:0]  idx_reg, idx_next;
    logic        pad_act_reg, pad_act_next;
    logic        first_reg, first_next;
    logic        lenph_reg, lenph_next;
    logic        done_reg, done_next;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] c_reg, c_next;
    logic [W-1:0] d_reg, d_next;
    logic [W-1:0] ak_reg, ak_next;
    logic [W-1:0] chain_reg [4];
    logic [W-1:0] chain_next [4];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;
    logic [AW-1:0] rd_addr;
    logic [W-1:0]  rd_data;

    logic          put_en;
    logic [7:0]    put_byte;
    logic [7:0]    len_byte;
    logic [W-1:0]  round_sum;
    logic [W-1:0]  round_rot;

    md5_ram #(
        .Width (md5_pkg::WordW),
        .Depth (md5_pkg::BlockWords)
    ) u_block_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign len_byte  = 8'(len_reg >> {pos_reg[2:0], 3'b000});
    assign round_sum = ak_reg + md5_pkg::md5_mix(rnd_reg[5:4], b_reg, c_reg, d_reg) + rd_data;
    assign round_rot = md5_pkg::md5_rotl(round_sum, md5_pkg::md5_rot_amount(rnd_reg));

    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 2'd3);

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        asm_next     = asm_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        pad_act_next = pad_act_reg;
        first_next   = first_reg;
        lenph_next   = lenph_reg;
        done_next    = done_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        ak_next      = ak_reg;
        for (int k = 0; k < 4; k++)
        begin
            chain_next[k] = chain_reg[k];
        end
        put_en   = 1'b0;
        put_byte = 8'h00;
        rd_addr  = md5_pkg::md5_msg_index(6'd0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (msg.byte_valid)
                    begin
                        put_en   = 1'b1;
                        put_byte = msg.data_byte;
                        len_next = len_reg + 64'd8;
                    end
                    if (msg.end_of_message)
                    begin
                        pad_act_next = 1'b1;
                        first_next   = 1'b1;
                        lenph_next   = 1'b0;
                        done_next    = 1'b0;
                    end
                    if (msg.byte_valid && pos_reg == md5_pkg::LastPos)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                if (first_reg)
                begin
                    put_byte   = md5_pkg::PadMark;
                    first_next = 1'b0;
                end
                else if (lenph_reg || pos_reg == md5_pkg::LenPos)
                begin
                    put_byte   = len_byte;
                    lenph_next = 1'b1;
                    if (pos_reg == md5_pkg::LastPos)
                    begin
                        done_next = 1'b1;
                    end
                end
                if (pos_reg == md5_pkg::LastPos)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                ak_next    = chain_reg[0] + md5_pkg::md5_round_const(6'd0);
                rd_addr    = md5_pkg::md5_msg_index(6'd0);
                rnd_next   = 6'd0;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_reg + round_rot;
                ak_next  = d_reg + md5_pkg::md5_round_const(rnd_reg + 6'd1);
                rd_addr  = md5_pkg::md5_msg_index(rnd_reg + 6'd1);
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == md5_pkg::LastRound)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (done_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_act_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (digest.ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            chain_next[k] = md5_pkg::md5_init(2'(k));
                        end
                        len_next     = 64'd0;
                        pos_next     = 6'd0;
                        pad_act_next = 1'b0;
                        first_next   = 1'b0;
                        lenph_next   = 1'b0;
                        done_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // gather bytes into little-endian words, write each completed word
        wr_en   = 1'b0;
        wr_addr = pos_reg[5:2];
        wr_data = {put_byte, asm_reg};
        if (put_en)
        begin
            pos_next = pos_reg + 6'd1;
            case (pos_reg[1:0])
                2'd0:    asm_next[7:0]   = put_byte;
                2'd1:    asm_next[15:8]  = put_byte;
                2'd2:    asm_next[23:16] = put_byte;
                default: wr_en = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 6'd0;
            len_reg     <= 64'd0;
            rnd_reg     <= 6'd0;
            idx_reg     <= 2'd0;
            pad_act_reg <= 1'b0;
            first_reg   <= 1'b0;
            lenph_reg   <= 1'b0;
            done_reg    <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= md5_pkg::md5_init(2'(k));
            end
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            pad_act_reg <= pad_act_next;
            first_reg   <= first_next;
            lenph_reg   <= lenph_next;
            done_reg    <= done_next;
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        ak_reg  <= ak_next;
    end

endmodule

// ----- tb/sv/md5_stream_hash_test.sv -----
// Self-checking testbench for md5_stream_hash: random byte-stream messages against an MD5 predictor.
module md5_stream_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ItemTarget  = 300;
    localparam int MinMessages = 15;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 40;
    localparam int BoundaryLen [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_txn_t;

    class digest_scoreboard;
        logic [31:0] chain [4];
        logic [7:0]  block_bytes [64];
        logic [63:0] length_bits;
        logic [31:0] round_k [64];
        int unsigned shift_amt [16];
        digest_txn_t digest_q [$];
        int          failures;

        function new();
            round_k = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
            };
            shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            failures = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = md5_pkg::Init0;
            chain[1] = md5_pkg::Init1;
            chain[2] = md5_pkg::Init2;
            chain[3] = md5_pkg::Init3;
            length_bits = '0;
        endfunction

        function void md5_compress();
            logic [31:0] m [16];
            logic [31:0] a, b, c, d, f, t, sum;
            int          g, ph;
            int unsigned s;
            for (int i = 0; i < 16; i++)
            begin
                m[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                        block_bytes[4*i+1], block_bytes[4*i]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++)
            begin
                ph = i / 16;
                case (ph)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                s = shift_amt[ph * 4 + i % 4];
                sum = a + f + round_k[i] + m[g];
                t = d;
                d = c;
                c = b;
                b = b + ((sum << s) | (sum >> (32 - s)));
                a = t;
            end
            chain[0] = chain[0] + a;
            chain[1] = chain[1] + b;
            chain[2] = chain[2] + c;
            chain[3] = chain[3] + d;
        endfunction

        function logic [5:0] store_byte(logic [5:0] pos, logic [7:0] v);
            block_bytes[pos] = v;
            if (pos == md5_pkg::LastPos)
                md5_compress();
            return pos + 6'd1;
        endfunction

        function void absorb_transaction(logic [7:0] data, logic bv, logic eom);
            logic [63:0] total;
            logic [5:0]  pos;
            digest_txn_t e;
            if (bv)
            begin
                pos = length_bits[8:3];
                void'(store_byte(pos, data));
                length_bits = length_bits + 64'd8;
            end
            if (!eom)
                return;
            total = length_bits;
            pos = store_byte(total[8:3], md5_pkg::PadMark);
            while (pos != md5_pkg::LenPos)
                pos = store_byte(pos, 8'h00);
            for (int k = 0; k < 8; k++)
                pos = store_byte(pos, total[8*k +: 8]);
            for (int k = 0; k < 4; k++)
            begin
                e.word  = chain[k];
                e.index = 2'(k);
                e.last  = (k == 3);
                digest_q.push_back(e);
            end
            restart();
        endfunction

        function void check_digest_word(logic [31:0] word, logic [1:0] index, logic last);
            digest_txn_t e;
            if (digest_q.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected digest word: expected none, got %08h index %0d last %0b",
                         $time, word, index, last);
                return;
            end
            e = digest_q.pop_front();
            if (word !== e.word)
            begin
                failures++;
                $display("%0t: digest_word expected %08h got %08h", $time, e.word, word);
            end
            if (index !== e.index)
            begin
                failures++;
                $display("%0t: word_index expected %0d got %0d", $time, e.index, index);
            end
            if (last !== e.last)
            begin
                failures++;
                $display("%0t: last_word expected %0b got %0b", $time, e.last, last);
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   items_sent;
    bit   send_burst;
    bit   take_burst;

    digest_scoreboard sb;

    md5_in_if  msg_if ();
    md5_out_if dig_if ();

    md5_stream_hash dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (dig_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("%0t: timeout with %0d digest words outstanding", $time, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_transaction(logic [7:0] data, logic bv, logic eom);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= data;
        msg_if.byte_valid     <= bv;
        msg_if.end_of_message <= eom;
        do
            @(posedge clk);
        while (!msg_if.ready);
        sb.absorb_transaction(data, bv, eom);
        items_sent++;
    endtask

    task automatic send_message(int len, bit eom_alone);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_transaction(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_transaction(8'($urandom_range(0, 255)), 1'b1, !eom_alone && (i == len - 1));
        end
        if (eom_alone || len == 0)
            send_transaction(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic collect_digest();
        int stall;
        int n;
        n = 0;
        forever
        begin
            if (n % 4 == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            stall = take_burst ? 0 : $urandom_range(0, 7);
            repeat (stall)
            begin
                dig_if.ready <= 1'b0;
                @(posedge clk);
            end
            dig_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!dig_if.valid);
            sb.check_digest_word(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
            n++;
        end
    endtask

    initial
    begin
        int pick;
        int len;
        int msgs;
        sb = new();
        items_sent = 0;
        send_burst = 1'b0;
        take_burst = 1'b0;
        rst_n                 <= 1'b0;
        msg_if.valid          <= 1'b0;
        msg_if.data_byte      <= 8'h00;
        msg_if.byte_valid     <= 1'b0;
        msg_if.end_of_message <= 1'b0;
        dig_if.ready          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            collect_digest();
        join_none

        // empty message, then "abc", then an ignored transaction
        send_transaction(8'h00, 1'b0, 1'b1);
        send_transaction(8'h61, 1'b1, 1'b0);
        send_transaction(8'h62, 1'b1, 1'b0);
        send_transaction(8'h63, 1'b1, 1'b1);
        send_transaction(8'hff, 1'b0, 1'b0);
        send_burst = 1'b1;
        send_transaction(8'h00, 1'b1, 1'b0);
        send_transaction(8'hff, 1'b1, 1'b0);
        send_transaction(8'h55, 1'b1, 1'b0);
        send_transaction(8'hff, 1'b0, 1'b1);
        send_burst = 1'b0;
        send_transaction(8'hff, 1'b1, 1'b1);
        send_transaction(8'h00, 1'b0, 1'b1);
        send_message(56, 1'b0);
        wait_drained();

        msgs = 0;
        while (items_sent < ItemTarget || msgs < MinMessages)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                len = $urandom_range(0, 8);
            else if (pick < 95)
                len = BoundaryLen[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 140);
            send_burst = ($urandom_range(0, 3) == 0);
            send_message(len, 1'($urandom_range(0, 1)));
            msgs++;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/md5_pkg.sv
hw/rtl/md5_if.sv
hw/rtl/md5_ram.sv
hw/rtl/md5_stream_hash.sv
tb/sv/md5_stream_hash_test.sv
